/* design/bsm_pkg.sv */
// Shared types, codes and constants of the bank switch mapper.
package bsm_pkg;

  // Bank number widths kept in the mapping
  localparam int PRG_BANK_BITS = 6;
  localparam int CHR_BANK_BITS = 8;

  // Fixed field widths
  localparam int CMD_W     = 2;
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int ROM_AW    = 19;
  localparam int TGT_W     = 2;
  localparam int LAST_W    = 6;
  localparam int APB_AW    = 2;
  localparam int APB_DW    = 32;
  localparam int PRG_OFS_W = 13;
  localparam int CHR_OFS_W = 10;

  localparam logic [LAST_W-1:0] PRG_LAST_RESET = LAST_W'(63);

  // Bus access kinds
  typedef enum logic [CMD_W-1:0] {
    CMD_CPU_RD = 2'd0,
    CMD_CPU_WR = 2'd1,
    CMD_PPU_RD = 2'd2,
    CMD_PPU_WR = 2'd3
  } cmd_e;

  // ROM target of a result item
  typedef enum logic [TGT_W-1:0] {
    TGT_NONE = 2'd0,
    TGT_PRG  = 2'd1,
    TGT_CHR  = 2'd2
  } tgt_e;

  // Mapper register blocks, chosen by CPU address bits 14:13
  typedef enum logic [1:0] {
    REG_BANK   = 2'd0,
    REG_MIRROR = 2'd1,
    REG_IRQ_LD = 2'd2,
    REG_IRQ_EN = 2'd3
  } reg_blk_e;

  // Mapping state seen by the address translation
  typedef struct packed {
    logic [LAST_W-1:0]           prg_last;
    logic                        prg_swap;
    logic                        chr_invert;
    logic                        hmirror;
    logic [7:0][DATA_W-1:0]      bank_regs;
  } bsm_state_t;

endpackage

/* design/bsm_ctrl.sv */
// Mapper registers, configuration register and scanline IRQ counter.
module bsm_ctrl import bsm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [ADDR_W-1:0]   address_i,
  input  logic [DATA_W-1:0]   write_data_i,
  input  logic                cfg_we_i,
  input  logic [LAST_W-1:0]   cfg_last_i,
  output bsm_state_t          state_o,
  output logic                irq_next_o
);

  logic [LAST_W-1:0]      prg_last_q;
  logic [2:0]             bank_sel_q, bank_sel_d;
  logic                   prg_swap_q, prg_swap_d;
  logic                   chr_inv_q, chr_inv_d;
  logic [7:0][DATA_W-1:0] bank_regs_q, bank_regs_d;
  logic                   hmirror_q, hmirror_d;
  logic [DATA_W-1:0]      irq_latch_q, irq_latch_d;
  logic [DATA_W-1:0]      irq_count_q, irq_count_d;
  logic                   reload_q, reload_d;
  logic                   irq_en_q, irq_en_d;
  logic                   irq_flag_q, irq_flag_d;
  logic                   last_a12_q, last_a12_d;

  logic                   cpu_wr, is_ppu, a12, odd;
  reg_blk_e               blk;

  assign blk    = reg_blk_e'(address_i[14:13]);
  assign odd    = address_i[0];
  assign a12    = address_i[12];
  assign cpu_wr = (cmd_e'(command_i) == CMD_CPU_WR) && address_i[15];
  assign is_ppu = command_i[1];

  // Next state for one item
  always_comb begin
    bank_sel_d  = bank_sel_q;
    prg_swap_d  = prg_swap_q;
    chr_inv_d   = chr_inv_q;
    bank_regs_d = bank_regs_q;
    hmirror_d   = hmirror_q;
    irq_latch_d = irq_latch_q;
    irq_count_d = irq_count_q;
    reload_d    = reload_q;
    irq_en_d    = irq_en_q;
    irq_flag_d  = irq_flag_q;
    last_a12_d  = last_a12_q;
    if (cpu_wr) begin
      case (blk)
        REG_BANK: begin
          if (odd) begin
            bank_regs_d[bank_sel_q] = write_data_i;
          end else begin
            bank_sel_d = write_data_i[2:0];
            prg_swap_d = write_data_i[6];
            chr_inv_d  = write_data_i[7];
          end
        end
        REG_MIRROR: begin
          if (!odd) hmirror_d = write_data_i[0];
        end
        REG_IRQ_LD: begin
          if (odd) begin
            irq_count_d = '0;
            reload_d    = 1'b1;
          end else begin
            irq_latch_d = write_data_i;
          end
        end
        REG_IRQ_EN: begin
          if (odd) begin
            irq_en_d = 1'b1;
          end else begin
            irq_en_d   = 1'b0;
            irq_flag_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (is_ppu) begin
      last_a12_d = a12;
      // a rising A12 steps the scanline counter
      if (a12 && !last_a12_q) begin
        if ((irq_count_q == '0) || reload_q) begin
          irq_count_d = irq_latch_q;
          reload_d    = 1'b0;
        end else begin
          irq_count_d = irq_count_q - DATA_W'(1);
        end
        if ((irq_count_d == '0) && irq_en_q) irq_flag_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_last_q  <= PRG_LAST_RESET;
      bank_sel_q  <= '0;
      prg_swap_q  <= 1'b0;
      chr_inv_q   <= 1'b0;
      bank_regs_q <= '0;
      hmirror_q   <= 1'b1;
      irq_latch_q <= '0;
      irq_count_q <= '0;
      reload_q    <= 1'b0;
      irq_en_q    <= 1'b0;
      irq_flag_q  <= 1'b0;
      last_a12_q  <= 1'b0;
    end else begin
      if (cfg_we_i) prg_last_q <= cfg_last_i;
      if (accept_i) begin
        bank_sel_q  <= bank_sel_d;
        prg_swap_q  <= prg_swap_d;
        chr_inv_q   <= chr_inv_d;
        bank_regs_q <= bank_regs_d;
        hmirror_q   <= hmirror_d;
        irq_latch_q <= irq_latch_d;
        irq_count_q <= irq_count_d;
        reload_q    <= reload_d;
        irq_en_q    <= irq_en_d;
        irq_flag_q  <= irq_flag_d;
        last_a12_q  <= last_a12_d;
      end
    end
  end

  assign state_o.prg_last   = prg_last_q;
  assign state_o.prg_swap   = prg_swap_q;
  assign state_o.chr_invert = chr_inv_q;
  assign state_o.hmirror    = hmirror_q;
  assign state_o.bank_regs  = bank_regs_q;
  assign irq_next_o         = irq_flag_d;

endmodule

/* design/bsm_xlate.sv */
// Program and character ROM address translation and nametable select.
module bsm_xlate import bsm_pkg::*; (
  input  logic [CMD_W-1:0]  command_i,
  input  logic [ADDR_W-1:0] address_i,
  input  bsm_state_t        state_i,
  output logic [ROM_AW-1:0] rom_address_o,
  output logic [TGT_W-1:0]  rom_target_o,
  output logic              chr_write_o,
  output logic              nametable_bank_o
);

  logic [PRG_BANK_BITS-1:0] last_bank, second_bank, prg_bank, r6, r7;
  logic [1:0]               prg_slot;
  logic [2:0]               chr_slot, chr_idx;
  logic [DATA_W-1:0]        chr_bank;
  logic [ROM_AW-1:0]        prg_addr, chr_addr;

  // Program slots: fixed last, fixed last-1, and R6/R7 swapped by mode
  assign last_bank   = state_i.prg_last[PRG_BANK_BITS-1:0];
  assign second_bank = last_bank - PRG_BANK_BITS'(1);
  assign r6          = state_i.bank_regs[6][PRG_BANK_BITS-1:0];
  assign r7          = state_i.bank_regs[7][PRG_BANK_BITS-1:0];
  assign prg_slot    = address_i[14:13];

  always_comb begin
    case (prg_slot)
      2'd0:    prg_bank = state_i.prg_swap ? second_bank : r6;
      2'd1:    prg_bank = state_i.prg_swap ? r7 : second_bank;
      2'd2:    prg_bank = state_i.prg_swap ? r6 : r7;
      default: prg_bank = last_bank;
    endcase
  end

  assign prg_addr = ROM_AW'({prg_bank, address_i[PRG_OFS_W-1:0]});

  // Character slots: 2KB pairs from R0/R1, 1KB banks from R2..R5
  assign chr_slot = address_i[12:10] ^ {state_i.chr_invert, 2'b00};
  assign chr_idx  = {1'b0, chr_slot[1:0]} + 3'd2;

  always_comb begin
    if (!chr_slot[2]) begin
      chr_bank = {state_i.bank_regs[{2'b00, chr_slot[1]}][DATA_W-1:1], chr_slot[0]};
    end else begin
      chr_bank = state_i.bank_regs[chr_idx];
    end
  end

  assign chr_addr = ROM_AW'({chr_bank[CHR_BANK_BITS-1:0], address_i[CHR_OFS_W-1:0]});

  // Result fields per access kind
  always_comb begin
    rom_address_o    = '0;
    rom_target_o     = TGT_NONE;
    chr_write_o      = 1'b0;
    nametable_bank_o = 1'b0;
    case (cmd_e'(command_i))
      CMD_CPU_RD: begin
        if (address_i[15]) begin
          rom_address_o = prg_addr;
          rom_target_o  = TGT_PRG;
        end
      end
      CMD_CPU_WR: begin
      end
      CMD_PPU_RD, CMD_PPU_WR: begin
        if (!address_i[13]) begin
          rom_address_o = chr_addr;
          rom_target_o  = TGT_CHR;
          chr_write_o   = (cmd_e'(command_i) == CMD_PPU_WR);
        end else if (address_i[13:8] != 6'h3F) begin
          nametable_bank_o = state_i.hmirror ? address_i[11] : address_i[10];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/bank_switch_mapper_with_line_irq_top.sv */
// Top level of the bank switch mapper with scanline IRQ counter.
// Takes one CPU or PPU bus access per item and returns one result item: the translated
// program or character ROM address, the nametable half and the IRQ line after the
// access. One item is accepted every clock cycle while the output register is empty or
// its result is being taken; the result appears in the output register in the cycle
// after acceptance, and a new item is taken in the same cycle that a waiting result is
// taken. The mapper registers and scanline counter load with the result, on acceptance.
// The last program bank index is set by any APB write and reads back at address 0.
module bank_switch_mapper_with_line_irq_top import bsm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [DATA_W-1:0] write_data_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ROM_AW-1:0] rom_address_o,
  output logic [TGT_W-1:0]  rom_target_o,
  output logic              chr_write_o,
  output logic              nametable_bank_o,
  output logic              irq_line_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic              accept, cfg_we, irq_next;
  bsm_state_t        state;
  logic [ROM_AW-1:0] rom_address_d, rom_address_q;
  logic [TGT_W-1:0]  rom_target_d, rom_target_q;
  logic              chr_write_d, chr_write_q;
  logic              nt_d, nt_q;
  logic              irq_q;
  logic              out_valid_q;

  // Handshakes
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pready     = 1'b1;
  // single register, so every write access lands in it
  assign cfg_we     = psel && penable && pwrite && pready;
  assign prdata     = (paddr == '0) ? APB_DW'(state.prg_last) : '0;

  bsm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .cfg_we_i     (cfg_we),
    .cfg_last_i   (pwdata[LAST_W-1:0]),
    .state_o      (state),
    .irq_next_o   (irq_next)
  );

  bsm_xlate u_xlate (
    .command_i        (command_i),
    .address_i        (address_i),
    .state_i          (state),
    .rom_address_o    (rom_address_d),
    .rom_target_o     (rom_target_d),
    .chr_write_o      (chr_write_d),
    .nametable_bank_o (nt_d)
  );

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rom_address_q <= rom_address_d;
      rom_target_q  <= rom_target_d;
      chr_write_q   <= chr_write_d;
      nt_q          <= nt_d;
      irq_q         <= irq_next;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rom_address_o    = rom_address_q;
  assign rom_target_o     = rom_target_q;
  assign chr_write_o      = chr_write_q;
  assign nametable_bank_o = nt_q;
  assign irq_line_o       = irq_q;

endmodule

/* design/bsm_checker.sv */
// Port-level checks of the mapper top level, and their binding.
module bsm_checker import bsm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [ROM_AW-1:0] rom_address_o,
  input logic [TGT_W-1:0]  rom_target_o,
  input logic              chr_write_o,
  input logic              nametable_bank_o
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rom_address_o))
    else $error("stalled result item changed");

  // every accepted item gives a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

  // no ROM access means a zero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rom_target_o == TGT_NONE) |-> (rom_address_o == '0))
    else $error("address given without ROM access");

  // character writes only land in character ROM
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chr_write_o |-> (rom_target_o == TGT_CHR) && !nametable_bank_o)
    else $error("character write outside character ROM");

  // target code is never the unused value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rom_target_o != 2'd3))
    else $error("unused ROM target code");

endmodule

bind bank_switch_mapper_with_line_irq_top bsm_checker u_bsm_checker (.*);

/* dv/tb_bank_switch_mapper_with_line_irq_top.sv */
// Self-checking testbench for the bank switch mapper with scanline IRQ counter.
`timescale 1ns / 100ps

module tb_bank_switch_mapper_with_line_irq_top;
  import bsm_pkg::*;

  localparam int PHASE_ITEMS    = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  // APB address of the last program bank register
  localparam logic [APB_AW-1:0] LAST_BANK_ADDR = APB_AW'(0);

  typedef struct {
    cmd_e              cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_access_t;

  typedef struct {
    logic [ROM_AW-1:0] rom_addr;
    tgt_e              target;
    logic              chr_wr;
    logic              nt_bank;
    logic              irq;
  } bus_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready_o;
  logic [CMD_W-1:0]  command = '0;
  logic [ADDR_W-1:0] address = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  logic [ROM_AW-1:0] rom_address_o;
  logic [TGT_W-1:0]  rom_target_o;
  logic              chr_write_o;
  logic              nametable_bank_o;
  logic              irq_line_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bank_switch_mapper_with_line_irq_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .command_i        (command),
    .address_i        (address),
    .write_data_i     (write_data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .rom_address_o    (rom_address_o),
    .rom_target_o     (rom_target_o),
    .chr_write_o      (chr_write_o),
    .nametable_bank_o (nametable_bank_o),
    .irq_line_o       (irq_line_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Clock
  always #4 clk_i = ~clk_i;

  // Mapper state as the predictor sees it
  logic [LAST_W-1:0] last_bank_cfg;
  logic [2:0]        sel_idx;
  logic              prg_swap;
  logic              chr_inv;
  logic [DATA_W-1:0] bank_val [8];
  logic              hmirror;
  logic [7:0]        line_latch;
  logic [7:0]        line_count;
  logic              reload_req;
  logic              irq_armed;
  logic              irq_pend;
  logic              prev_a12;

  bus_access_t pending_accesses[$];
  bus_result_t expected_results[$];
  bus_access_t cur_access;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_armed = 1'b0;
  logic out_hold = 1'b0;
  int fail_count = 0;
  int checked_count = 0;
  int irq_seen = 0;
  int chr_wr_seen = 0;
  int stall_cycles = 0;

  // Works out the result of one bus access and moves the mapper state on
  function automatic bus_result_t map_access(bus_access_t acc);
    bus_result_t res;
    logic [13:0] pa;
    logic [PRG_BANK_BITS-1:0] last_bank;
    logic [PRG_BANK_BITS-1:0] prg_bank;
    logic [CHR_BANK_BITS-1:0] chr_bank;
    logic [2:0] chr_slot;
    res.rom_addr = '0;
    res.target   = TGT_NONE;
    res.chr_wr   = 1'b0;
    res.nt_bank  = 1'b0;
    case (acc.cmd)
      CMD_CPU_RD: begin
        if (acc.addr[15]) begin
          last_bank = last_bank_cfg[PRG_BANK_BITS-1:0];
          case (acc.addr[14:13])
            2'd0: prg_bank = prg_swap ? last_bank - 1'b1 : bank_val[6][PRG_BANK_BITS-1:0];
            2'd1: prg_bank = prg_swap ? bank_val[7][PRG_BANK_BITS-1:0] : last_bank - 1'b1;
            2'd2: prg_bank = prg_swap ? bank_val[6][PRG_BANK_BITS-1:0]
                                      : bank_val[7][PRG_BANK_BITS-1:0];
            default: prg_bank = last_bank;
          endcase
          res.rom_addr = ROM_AW'({prg_bank, acc.addr[PRG_OFS_W-1:0]});
          res.target   = TGT_PRG;
        end
      end
      CMD_CPU_WR: begin
        // register decode by 8KB block and address bit 0
        if (acc.addr[15]) begin
          case (reg_blk_e'(acc.addr[14:13]))
            REG_BANK: begin
              if (acc.addr[0]) begin
                bank_val[sel_idx] = acc.data;
              end else begin
                sel_idx  = acc.data[2:0];
                prg_swap = acc.data[6];
                chr_inv  = acc.data[7];
              end
            end
            REG_MIRROR: begin
              if (!acc.addr[0]) hmirror = acc.data[0];
            end
            REG_IRQ_LD: begin
              if (acc.addr[0]) begin
                line_count = '0;
                reload_req = 1'b1;
              end else begin
                line_latch = acc.data;
              end
            end
            default: begin
              if (acc.addr[0]) begin
                irq_armed = 1'b1;
              end else begin
                irq_armed = 1'b0;
                irq_pend  = 1'b0;
              end
            end
          endcase
        end
      end
      default: begin
        pa = acc.addr[13:0];
        // A12 rising edge steps the scanline counter
        if (pa[12] && !prev_a12) begin
          if (line_count == '0 || reload_req) begin
            line_count = line_latch;
            reload_req = 1'b0;
          end else begin
            line_count = line_count - 1'b1;
          end
          if (line_count == '0 && irq_armed) irq_pend = 1'b1;
        end
        prev_a12 = pa[12];
        if (!pa[13]) begin
          chr_slot = pa[12:10] ^ {chr_inv, 2'b00};
          if (!chr_slot[2]) chr_bank = {bank_val[{2'b00, chr_slot[1]}][7:1], chr_slot[0]};
          else chr_bank = bank_val[chr_slot - 3'd2][CHR_BANK_BITS-1:0];
          res.rom_addr = ROM_AW'({chr_bank, pa[CHR_OFS_W-1:0]});
          res.target   = TGT_CHR;
          res.chr_wr   = (acc.cmd == CMD_PPU_WR);
        end else if (pa < 14'h3F00) begin
          res.nt_bank = hmirror ? pa[11] : pa[10];
        end
      end
    endcase
    res.irq = irq_pend;
    return res;
  endfunction

  function automatic void push_access(cmd_e c, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    bus_access_t acc;
    acc.cmd  = c;
    acc.addr = a;
    acc.data = d;
    pending_accesses.push_back(acc);
  endfunction

  // Address of a mapper register: block and even/odd, other bits random
  function automatic logic [ADDR_W-1:0] reg_addr(reg_blk_e blk, logic odd);
    return {1'b1, blk, 12'($urandom), odd};
  endfunction

  function automatic cmd_e ppu_cmd();
    return $urandom_range(1) ? CMD_PPU_WR : CMD_PPU_RD;
  endfunction

  // Queues one random sequence of accesses, returns how many were queued
  function automatic int queue_random_sequence();
    int kind;
    int n;
    logic [ADDR_W-1:0] a;
    kind = $urandom_range(99);
    n = 0;
    if (kind < 20) begin
      // bank select followed by bank data
      push_access(CMD_CPU_WR, reg_addr(REG_BANK, 1'b0), 8'($urandom));
      push_access(CMD_CPU_WR, reg_addr(REG_BANK, 1'b1), 8'($urandom));
      n = 2;
    end else if (kind < 28) begin
      push_access(CMD_CPU_WR, reg_addr(REG_MIRROR, 1'($urandom)), 8'($urandom));
      n = 1;
    end else if (kind < 44) begin
      // scanline IRQ setup: short latch, reload, then enable or acknowledge
      push_access(CMD_CPU_WR, reg_addr(REG_IRQ_LD, 1'b0),
                  $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(7)));
      push_access(CMD_CPU_WR, reg_addr(REG_IRQ_LD, 1'b1), 8'($urandom));
      push_access(CMD_CPU_WR, reg_addr(REG_IRQ_EN, $urandom_range(3) != 0), 8'($urandom));
      n = 3;
    end else if (kind < 66) begin
      // pattern fetches with A12 toggling, the odd nametable access in between
      repeat ($urandom_range(2, 8)) begin
        push_access(ppu_cmd(), {2'($urandom), 2'b00, 12'($urandom)}, 8'($urandom));
        push_access(ppu_cmd(), {2'($urandom), 2'b01, 12'($urandom)}, 8'($urandom));
        n += 2;
        if ($urandom_range(3) == 0) begin
          push_access(ppu_cmd(), {2'($urandom), 2'b10, 12'($urandom)}, 8'($urandom));
          n++;
        end
      end
    end else if (kind < 80) begin
      a = 16'($urandom);
      if ($urandom_range(4) != 0) a[15] = 1'b1;
      push_access(CMD_CPU_RD, a, 8'($urandom));
      n = 1;
    end else if (kind < 90) begin
      push_access(ppu_cmd(), 16'($urandom), 8'($urandom));
      n = 1;
    end else begin
      push_access(cmd_e'($urandom_range(3)), 16'($urandom), 8'($urandom));
      n = 1;
    end
    return n;
  endfunction

  // Input driver: predicts on acceptance, then offers the next pending item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) expected_results.push_back(map_access(cur_access));
      if (!in_valid || in_ready_o) begin
        if (pending_accesses.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_access = pending_accesses.pop_front();
          in_valid   <= 1'b1;
          command    <= cur_access.cmd;
          address    <= cur_access.addr;
          write_data <= cur_access.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    bus_result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (want.irq) irq_seen++;
          if (want.chr_wr) chr_wr_seen++;
          if (rom_address_o !== want.rom_addr) begin
            $error("rom_address: expected %h, got %h", want.rom_addr, rom_address_o);
            fail_count++;
          end
          if (rom_target_o !== want.target) begin
            $error("rom_target: expected %0d, got %0d", want.target, rom_target_o);
            fail_count++;
          end
          if (chr_write_o !== want.chr_wr) begin
            $error("chr_write: expected %b, got %b", want.chr_wr, chr_write_o);
            fail_count++;
          end
          if (nametable_bank_o !== want.nt_bank) begin
            $error("nametable_bank: expected %b, got %b", want.nt_bank, nametable_bank_o);
            fail_count++;
          end
          if (irq_line_o !== want.irq) begin
            $error("irq_line: expected %b, got %b", want.irq, irq_line_o);
            fail_count++;
          end
        end
      end
      out_ready <= !out_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    while (!hold_armed) @(posedge clk_i);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    out_hold <= 1'b0;
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_last_bank(logic [LAST_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LAST_BANK_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    last_bank_cfg = value;
  endtask

  task automatic wait_drained();
    while (pending_accesses.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase(int tx_pct, int rx_pct, logic [LAST_W-1:0] last_bank);
    int queued;
    queued = 0;
    write_last_bank(last_bank);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (queued < PHASE_ITEMS) queued += queue_random_sequence();
    if (tx_pct == 0 && rx_pct == 0) hold_armed = 1'b1;
    wait_drained();
  endtask

  // Stimulus
  initial begin
    last_bank_cfg = PRG_LAST_RESET;
    sel_idx    = '0;
    prg_swap   = 1'b0;
    chr_inv    = 1'b0;
    foreach (bank_val[i]) bank_val[i] = '0;
    hmirror    = 1'b1;
    line_latch = '0;
    line_count = '0;
    reload_req = 1'b0;
    irq_armed  = 1'b0;
    irq_pend   = 1'b0;
    prev_a12   = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset value of the last bank
    push_access(CMD_CPU_RD, 16'h0000, 8'h00);   // below the ROM window
    push_access(CMD_CPU_WR, 16'h6000, 8'hFF);   // ignored low write
    push_access(CMD_CPU_WR, 16'h8000, 8'h06);
    push_access(CMD_CPU_WR, 16'h8001, 8'hFF);   // R6, wraps to bank bits
    push_access(CMD_CPU_WR, 16'h8000, 8'hC7);   // R7, swap and invert
    push_access(CMD_CPU_WR, 16'h8001, 8'hA5);
    push_access(CMD_CPU_RD, 16'h8000, 8'h00);
    push_access(CMD_CPU_RD, 16'hA000, 8'h00);
    push_access(CMD_CPU_RD, 16'hDFFF, 8'h00);
    push_access(CMD_CPU_RD, 16'hFFFF, 8'h00);
    push_access(CMD_CPU_WR, 16'hA000, 8'h00);   // vertical mirroring
    push_access(CMD_CPU_WR, 16'hA001, 8'hFF);   // RAM protect, ignored
    push_access(CMD_PPU_RD, 16'h2400, 8'h00);
    push_access(CMD_PPU_WR, 16'hFF00, 8'hFF);   // palette area, high bits set
    push_access(CMD_CPU_WR, 16'hC000, 8'h01);
    push_access(CMD_CPU_WR, 16'hC001, 8'h00);
    push_access(CMD_CPU_WR, 16'hE001, 8'h00);
    push_access(CMD_PPU_WR, 16'h0000, 8'h3C);   // character write
    push_access(CMD_PPU_RD, 16'h1000, 8'h00);   // edge: reload
    push_access(CMD_PPU_RD, 16'h0FFF, 8'h00);
    push_access(CMD_PPU_RD, 16'hD3FF, 8'h00);   // edge: count hits zero
    push_access(CMD_CPU_RD, 16'h7FFF, 8'h00);
    push_access(CMD_CPU_WR, 16'hE000, 8'h00);   // acknowledge
    push_access(CMD_CPU_WR, 16'h8000, 8'h00);
    push_access(CMD_PPU_RD, 16'h07FF, 8'h00);
    wait_drained();

    // Random phases: sender light/receiver heavy, reversed, then no idling
    run_random_phase(9, 59, LAST_W'(3));
    run_random_phase(59, 9, LAST_W'($urandom_range(4, 62)));
    run_random_phase(0, 0, LAST_W'(63));

    if (expected_results.size() != 0) begin
      $error("%0d expected result items never arrived", expected_results.size());
      fail_count++;
    end
    $display("Checked %0d bus accesses over last-bank settings 63, 3, mid-range and 63;",
             checked_count);
    $display("%0d results with the IRQ line high, %0d character writes.",
             irq_seen, chr_wr_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
design/bsm_pkg.sv
design/bsm_ctrl.sv
design/bsm_xlate.sv
design/bank_switch_mapper_with_line_irq_top.sv
design/bsm_checker.sv
dv/tb_bank_switch_mapper_with_line_irq_top.sv
